/* hw/rtl/gda_pkg.sv */
// Shared types, constants and calendar functions for the date arithmetic core.
`default_nettype none
package gda_pkg;

    // Only the low COUNT_WIDTH bits of the day count take part in add and subtract
    localparam int COUNT_WIDTH = 16;

    localparam int YEAR_W = 14;
    localparam int ORD_W  = 22;
    localparam int SUM_W  = ORD_W + 3;
    localparam int DIFF_W = 23;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [ORD_W-1:0]  ORD_MAX  = 22'd3652059;

    // Days in 400, 100, 4 and 1 years
    localparam logic [ORD_W-1:0] DAYS_400 = 22'd146097;
    localparam logic [ORD_W-1:0] DAYS_100 = 22'd36524;
    localparam logic [ORD_W-1:0] DAYS_4   = 22'd1461;
    localparam logic [ORD_W-1:0] DAYS_1   = 22'd365;

    // floor(x/100) = (x * 5243) >> 19 for x below 16384
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Operation kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_SUB  = 2'd1;
    localparam logic [1:0] KIND_DIFF = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SAT,
        OP_MUL,
        OP_BASE,
        OP_ORD,
        OP_OFFS,
        OP_D400,
        OP_D100,
        OP_D4,
        OP_D1,
        OP_MON,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_b;    // work on the second date
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       ge400;
        logic       ge100;
        logic       ge4;
        logic       ge1;
        logic       gemon;
    } t_status;

    // Length of month m (1..12)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            len = 5'd30;
        end else if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

    // Days in the year before the first of month m
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        if (leap && m > 4'd2) begin
            c = c + 9'd1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/gregorian_date_arithmetic_core.sv */
// Top level of the proleptic Gregorian date arithmetic core.
//
// Usage: drive an item on the i_* ports and raise start. The item is taken
// at a rising edge where start is high and busy is low; busy then stays high
// until the result is written. The result appears on the o_* ports with
// o_valid high for exactly one cycle; there is no back pressure, so the
// receiver must take it in that cycle. Result ports hold their last value
// between strobes.
// Steps, from the accepting edge to the result:
//   kind 2 (difference): two date-to-ordinal passes, then the difference.
//   kind 0/1 (add/sub): one date-to-ordinal pass, the offset, then the
//     400-, 100-, 4- and 1-year stages and the month stage, each repeating
//     while its subtract applies, then the date is written.
//   kind 3: one date-to-ordinal pass, then all fields zero.
// One item is in flight at a time; a new item may be started in the cycle
// the strobe is shown. The repeated decomposition steps set the rate of add
// and subtract items. Synchronous reset returns the controller to idle and
// drops the strobe; result registers are not cleared.
`default_nettype none
module gregorian_date_arithmetic_core import gda_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_kind,
    input  wire logic [4:0]          i_day,
    input  wire logic [3:0]          i_month,
    input  wire logic [YEAR_W-1:0]   i_year,
    input  wire logic [15:0]         i_day_count,
    input  wire logic [4:0]          i_other_day,
    input  wire logic [3:0]          i_other_month,
    input  wire logic [YEAR_W-1:0]   i_other_year,
    output logic                     o_valid,
    output logic [4:0]               o_result_day,
    output logic [3:0]               o_result_month,
    output logic [YEAR_W-1:0]        o_result_year,
    output logic signed [DIFF_W-1:0] o_day_difference,
    output logic                     o_out_of_range
);

    t_cmd    w_cmd;
    t_status w_status;

    gda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    gda_datapath u_dp (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_kind           (i_kind),
        .i_day            (i_day),
        .i_month          (i_month),
        .i_year           (i_year),
        .i_day_count      (i_day_count),
        .i_other_day      (i_other_day),
        .i_other_month    (i_other_month),
        .i_other_year     (i_other_year),
        .o_status         (w_status),
        .o_result_day     (o_result_day),
        .o_result_month   (o_result_month),
        .o_result_year    (o_result_year),
        .o_day_difference (o_day_difference),
        .o_out_of_range   (o_out_of_range)
    );

endmodule
`default_nettype wire

/* hw/rtl/gda_datapath.sv */
// Datapath: date to ordinal conversion, offset, ordinal to date decomposition.
`default_nettype none
module gda_datapath import gda_pkg::*; (
    input  wire logic                i_clk,
    input  wire t_cmd                i_cmd,
    input  wire logic [1:0]          i_kind,
    input  wire logic [4:0]          i_day,
    input  wire logic [3:0]          i_month,
    input  wire logic [YEAR_W-1:0]   i_year,
    input  wire logic [15:0]         i_day_count,
    input  wire logic [4:0]          i_other_day,
    input  wire logic [3:0]          i_other_month,
    input  wire logic [YEAR_W-1:0]   i_other_year,
    output t_status                  o_status,
    output logic [4:0]               o_result_day,
    output logic [3:0]               o_result_month,
    output logic [YEAR_W-1:0]        o_result_year,
    output logic signed [DIFF_W-1:0] o_day_difference,
    output logic                     o_out_of_range
);

    // Captured item
    logic [1:0]             r_kind;
    logic [4:0]             r_d0, r_d1;
    logic [3:0]             r_m0, r_m1;
    logic [YEAR_W-1:0]      r_y0, r_y1;
    logic [COUNT_WIDTH-1:0] r_cnt;

    // Ordinal computation
    logic [YEAR_W-1:0] r_yy;
    logic [3:0]        r_mm;
    logic [4:0]        r_dd;
    logic [6:0]        r_q100y, r_q100p;
    logic [ORD_W-1:0]  r_p365, r_ybase;
    logic              r_leap;
    logic [ORD_W-1:0]  r_ord_a, r_ord_b;

    // Decomposition
    logic [ORD_W-1:0]  r_n;
    logic [YEAR_W-1:0] r_yacc;
    logic [1:0]        r_c100, r_c1;
    logic [4:0]        r_c4;
    logic [3:0]        r_mon;
    logic              r_oor;

    // Result
    logic [4:0]        r_res_day;
    logic [3:0]        r_res_month;
    logic [YEAR_W-1:0] r_res_year;
    logic [DIFF_W-1:0] r_res_diff;
    logic              r_res_oor;

    logic [4:0]        w_dsel;
    logic [3:0]        w_msel, w_msat;
    logic [YEAR_W-1:0] w_ysel, w_ysat, w_p, w_h100;
    logic [26:0]       w_prod_y, w_prod_p;
    logic [ORD_W-1:0]  w_p365, w_ybase, w_ord;
    logic              w_leap, w_rleap;
    logic [4:0]        w_ml, w_dclamp, w_mlr;
    logic [SUM_W-1:0]  w_sum_m1, w_dif_m1;
    logic              w_over, w_under;

    // Select the date being converted and saturate its year and month
    always_comb begin
        w_dsel = i_cmd.sel_b ? r_d1 : r_d0;
        w_msel = i_cmd.sel_b ? r_m1 : r_m0;
        w_ysel = i_cmd.sel_b ? r_y1 : r_y0;
        if (w_ysel == '0) begin
            w_ysat = 14'd1;
        end else if (w_ysel > YEAR_MAX) begin
            w_ysat = YEAR_MAX;
        end else begin
            w_ysat = w_ysel;
        end
        if (w_msel == 4'd0) begin
            w_msat = 4'd1;
        end else if (w_msel > 4'd12) begin
            w_msat = 4'd12;
        end else begin
            w_msat = w_msel;
        end
    end

    // Year terms: products by reciprocal and by 365
    always_comb begin
        w_p      = r_yy - 14'd1;
        w_prod_y = 27'(r_yy) * 27'(RECIP_100);
        w_prod_p = 27'(w_p) * 27'(RECIP_100);
        w_p365   = 22'(w_p) * 22'd365;
    end

    // Leap year and day count before the year
    always_comb begin
        w_h100  = 14'(r_q100y) * 14'd100;
        w_leap  = (r_yy[1:0] == 2'd0) && ((w_h100 != r_yy) || (r_q100y[1:0] == 2'd0));
        w_ybase = r_p365 + 22'(w_p[YEAR_W-1:2]) - 22'(r_q100p) + 22'(r_q100p[6:2]);
    end

    // Full ordinal with clamped day
    always_comb begin
        w_ml = month_len(r_mm, r_leap);
        if (r_dd == 5'd0) begin
            w_dclamp = 5'd1;
        end else if (r_dd > w_ml) begin
            w_dclamp = w_ml;
        end else begin
            w_dclamp = r_dd;
        end
        w_ord = r_ybase + 22'(cum_days(r_mm, r_leap)) + 22'(w_dclamp);
    end

    // Offset by the count, zero based, with range check
    always_comb begin
        w_sum_m1 = SUM_W'(r_ord_a) + SUM_W'(r_cnt) - SUM_W'(1);
        w_dif_m1 = SUM_W'(r_ord_a) - SUM_W'(r_cnt) - SUM_W'(1);
        w_over   = w_sum_m1 >= SUM_W'(ORD_MAX);
        w_under  = SUM_W'(r_ord_a) <= SUM_W'(r_cnt);
    end

    // Leap year of the decomposed year follows from the cycle counters
    always_comb begin
        w_rleap = (r_c1 == 2'd3) && ((r_c4 != 5'd24) || (r_c100 == 2'd3));
        w_mlr   = month_len(r_mon, w_rleap);
    end

    // Status flags for the controller
    always_comb begin
        o_status.kind  = r_kind;
        o_status.ge400 = r_n >= DAYS_400;
        o_status.ge100 = (r_n >= DAYS_100) && (r_c100 != 2'd3);
        o_status.ge4   = r_n >= DAYS_4;
        o_status.ge1   = (r_n >= DAYS_1) && (r_c1 != 2'd3);
        o_status.gemon = (r_mon != 4'd12) && (r_n >= 22'(w_mlr));
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_kind <= i_kind;
                r_d0   <= i_day;
                r_m0   <= i_month;
                r_y0   <= i_year;
                r_cnt  <= i_day_count[COUNT_WIDTH-1:0];
                r_d1   <= i_other_day;
                r_m1   <= i_other_month;
                r_y1   <= i_other_year;
            end
            OP_SAT: begin
                r_yy <= w_ysat;
                r_mm <= w_msat;
                r_dd <= w_dsel;
            end
            OP_MUL: begin
                r_q100y <= w_prod_y[RECIP_SHIFT+6:RECIP_SHIFT];
                r_q100p <= w_prod_p[RECIP_SHIFT+6:RECIP_SHIFT];
                r_p365  <= w_p365;
            end
            OP_BASE: begin
                r_leap  <= w_leap;
                r_ybase <= w_ybase;
            end
            OP_ORD: begin
                if (i_cmd.sel_b) begin
                    r_ord_b <= w_ord;
                end else begin
                    r_ord_a <= w_ord;
                end
            end
            OP_OFFS: begin
                r_yacc <= 14'd1;
                r_c100 <= 2'd0;
                r_c4   <= 5'd0;
                r_c1   <= 2'd0;
                r_mon  <= 4'd1;
                if (r_kind == KIND_ADD) begin
                    r_oor <= w_over;
                    r_n   <= w_over ? (ORD_MAX - 22'd1) : w_sum_m1[ORD_W-1:0];
                end else begin
                    r_oor <= w_under;
                    r_n   <= w_under ? '0 : w_dif_m1[ORD_W-1:0];
                end
            end
            OP_D400: begin
                if (o_status.ge400) begin
                    r_n    <= r_n - DAYS_400;
                    r_yacc <= r_yacc + 14'd400;
                end
            end
            OP_D100: begin
                if (o_status.ge100) begin
                    r_n    <= r_n - DAYS_100;
                    r_yacc <= r_yacc + 14'd100;
                    r_c100 <= r_c100 + 2'd1;
                end
            end
            OP_D4: begin
                if (o_status.ge4) begin
                    r_n    <= r_n - DAYS_4;
                    r_yacc <= r_yacc + 14'd4;
                    r_c4   <= r_c4 + 5'd1;
                end
            end
            OP_D1: begin
                if (o_status.ge1) begin
                    r_n    <= r_n - DAYS_1;
                    r_yacc <= r_yacc + 14'd1;
                    r_c1   <= r_c1 + 2'd1;
                end
            end
            OP_MON: begin
                if (o_status.gemon) begin
                    r_n   <= r_n - 22'(w_mlr);
                    r_mon <= r_mon + 4'd1;
                end
            end
            OP_FIN: begin
                if (r_kind == KIND_ADD || r_kind == KIND_SUB) begin
                    r_res_day   <= r_n[4:0] + 5'd1;
                    r_res_month <= r_mon;
                    r_res_year  <= r_yacc;
                    r_res_diff  <= '0;
                    r_res_oor   <= r_oor;
                end else if (r_kind == KIND_DIFF) begin
                    r_res_day   <= '0;
                    r_res_month <= '0;
                    r_res_year  <= '0;
                    r_res_diff  <= DIFF_W'(r_ord_a) - DIFF_W'(r_ord_b);
                    r_res_oor   <= 1'b0;
                end else begin
                    // unused kind: all fields zero
                    r_res_day   <= '0;
                    r_res_month <= '0;
                    r_res_year  <= '0;
                    r_res_diff  <= '0;
                    r_res_oor   <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result_day     = r_res_day;
    assign o_result_month   = r_res_month;
    assign o_result_year    = r_res_year;
    assign o_day_difference = $signed(r_res_diff);
    assign o_out_of_range   = r_res_oor;

endmodule
`default_nettype wire

/* hw/rtl/gda_ctrl.sv */
// Controller state machine sequencing the date arithmetic datapath.
`default_nettype none
module gda_ctrl import gda_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_valid
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_SAT  = 12'b0000_0000_0010,
        ST_MUL  = 12'b0000_0000_0100,
        ST_BASE = 12'b0000_0000_1000,
        ST_ORD  = 12'b0000_0001_0000,
        ST_OFFS = 12'b0000_0010_0000,
        ST_D400 = 12'b0000_0100_0000,
        ST_D100 = 12'b0000_1000_0000,
        ST_D4   = 12'b0001_0000_0000,
        ST_D1   = 12'b0010_0000_0000,
        ST_MON  = 12'b0100_0000_0000,
        ST_FIN  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_valid;

    // Next state and datapath command
    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        o_cmd.op    = OP_NONE;
        o_cmd.sel_b = r_second;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_second = 1'b0;
                    n_state  = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.op = OP_SAT;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_BASE;
            end
            ST_BASE: begin
                o_cmd.op = OP_BASE;
                n_state  = ST_ORD;
            end
            ST_ORD: begin
                o_cmd.op = OP_ORD;
                if (i_status.kind == KIND_DIFF && !r_second) begin
                    n_second = 1'b1;
                    n_state  = ST_SAT;
                end else if (i_status.kind == KIND_ADD || i_status.kind == KIND_SUB) begin
                    n_state = ST_OFFS;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_OFFS: begin
                o_cmd.op = OP_OFFS;
                n_state  = ST_D400;
            end
            // Each step stage repeats while its subtract applies
            ST_D400: begin
                o_cmd.op = OP_D400;
                if (!i_status.ge400) begin
                    n_state = ST_D100;
                end
            end
            ST_D100: begin
                o_cmd.op = OP_D100;
                if (!i_status.ge100) begin
                    n_state = ST_D4;
                end
            end
            ST_D4: begin
                o_cmd.op = OP_D4;
                if (!i_status.ge4) begin
                    n_state = ST_D1;
                end
            end
            ST_D1: begin
                o_cmd.op = OP_D1;
                if (!i_status.ge1) begin
                    n_state = ST_MON;
                end
            end
            ST_MON: begin
                o_cmd.op = OP_MON;
                if (!i_status.gemon) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_second <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_valid  <= (r_state == ST_FIN);
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

/* hw/rtl/gda_checker.sv */
// Port-level assertions for the date arithmetic core, bound to the top level.
`default_nettype none
module gda_checker import gda_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire logic [YEAR_W-1:0]   o_result_year,
    input wire logic signed [DIFF_W-1:0] o_day_difference,
    input wire logic                o_out_of_range
);

    // An accepted item keeps the core busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("core not busy after accepting an item");

    // The result strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // The core is idle again when its result is shown
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while result shown");

    // A clamped result sits at one of the limit years
    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_result_year == YEAR_MAX || o_result_year == 14'd1)
        else $error("out of range result not at a limit date");

    // A date result carries no difference
    a_date_nodiff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_year != '0 |-> o_day_difference == '0)
        else $error("date result with nonzero difference");

endmodule

bind gregorian_date_arithmetic_core gda_checker u_gda_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_result_year    (o_result_year),
    .o_day_difference (o_day_difference),
    .o_out_of_range   (o_out_of_range)
);
`default_nettype wire

/* tb/gregorian_date_arithmetic_core_test.sv */
// Self-checking testbench for the Gregorian date add, subtract and difference core.
`default_nettype none
module gregorian_date_arithmetic_core_test;
    import gda_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         LAST_SERIAL  = 3652059;   // serial of 31/12/9999
    localparam int         STALL_LIMIT  = 5000;
    localparam int         TAIL_CYCLES  = 200;
    localparam int         REPORT_LIMIT = 10;

    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } cal_date_t;

    typedef struct packed {
        logic [1:0] kind;
        cal_date_t  first;
        logic [15:0] count;
        cal_date_t  second;
    } date_item_t;

    typedef struct packed {
        cal_date_t                date;
        logic signed [DIFF_W-1:0] diff;
        logic                     oor;
    } date_result_t;

    typedef struct packed {
        logic         known;
        date_item_t   it;
        date_result_t res;
    } stimulus_row_t;

    typedef struct packed {
        date_item_t   it;
        date_result_t res;
    } pending_t;

    localparam cal_date_t    FIRST_DAY = '{5'd1, 4'd1, 14'd1};
    localparam cal_date_t    LAST_DAY  = '{5'd31, 4'd12, 14'd9999};
    localparam cal_date_t    RAW_ONES  = '{5'd31, 4'd15, 14'h3FFF};
    localparam cal_date_t    RAW_ZERO  = '0;
    localparam date_result_t NO_RESULT = '0;

    localparam int N_DIRECTED = 24;

    // Directed items; rows with known set carry their expected result
    localparam stimulus_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, '{KIND_ADD, FIRST_DAY, 16'd0, FIRST_DAY}, '{FIRST_DAY, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_ADD, LAST_DAY, 16'hFFFF, FIRST_DAY}, '{LAST_DAY, 23'sd0, 1'b1}},
        '{1'b1, '{KIND_SUB, FIRST_DAY, 16'd1, FIRST_DAY}, '{FIRST_DAY, 23'sd0, 1'b1}},
        '{1'b1, '{KIND_SUB, FIRST_DAY, 16'hFFFF, LAST_DAY}, '{FIRST_DAY, 23'sd0, 1'b1}},
        '{1'b1, '{KIND_DIFF, LAST_DAY, 16'd0, FIRST_DAY},
                '{RAW_ZERO, 23'sd3652058, 1'b0}},
        '{1'b1, '{KIND_DIFF, FIRST_DAY, 16'hFFFF, LAST_DAY},
                '{RAW_ZERO, -23'sd3652058, 1'b0}},
        '{1'b1, '{KIND_UNUSED, RAW_ONES, 16'hFFFF, RAW_ONES}, NO_RESULT},
        '{1'b1, '{KIND_UNUSED, RAW_ZERO, 16'd0, RAW_ZERO}, NO_RESULT},
        // malformed dates saturate to the nearest legal one
        '{1'b1, '{KIND_DIFF, RAW_ZERO, 16'd0, FIRST_DAY}, '{RAW_ZERO, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_DIFF, RAW_ONES, 16'd0, LAST_DAY}, '{RAW_ZERO, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_ADD, RAW_ZERO, 16'd0, RAW_ONES}, '{FIRST_DAY, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_SUB, RAW_ONES, 16'd0, RAW_ZERO}, '{LAST_DAY, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_ADD, '{5'd31, 4'd4, 14'd2020}, 16'd0, FIRST_DAY},
                '{'{5'd30, 4'd4, 14'd2020}, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_DIFF, '{5'd31, 4'd2, 14'd2001}, 16'd0, '{5'd28, 4'd2, 14'd2001}},
                '{RAW_ZERO, 23'sd0, 1'b0}},
        // leap rule and month, year rollover
        '{1'b1, '{KIND_ADD, '{5'd28, 4'd2, 14'd2000}, 16'd1, FIRST_DAY},
                '{'{5'd29, 4'd2, 14'd2000}, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_ADD, '{5'd28, 4'd2, 14'd1900}, 16'd1, FIRST_DAY},
                '{'{5'd1, 4'd3, 14'd1900}, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_ADD, '{5'd31, 4'd12, 14'd1999}, 16'd1, FIRST_DAY},
                '{'{5'd1, 4'd1, 14'd2000}, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_SUB, '{5'd1, 4'd3, 14'd2004}, 16'd1, FIRST_DAY},
                '{'{5'd29, 4'd2, 14'd2004}, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_SUB, '{5'd1, 4'd1, 14'd2}, 16'd365, FIRST_DAY},
                '{FIRST_DAY, 23'sd0, 1'b0}},
        // exactly at and one past the last day
        '{1'b1, '{KIND_ADD, '{5'd30, 4'd12, 14'd9999}, 16'd1, FIRST_DAY},
                '{LAST_DAY, 23'sd0, 1'b0}},
        '{1'b1, '{KIND_ADD, '{5'd30, 4'd12, 14'd9999}, 16'd2, FIRST_DAY},
                '{LAST_DAY, 23'sd0, 1'b1}},
        '{1'b0, '{KIND_ADD, '{5'd15, 4'd6, 14'd2024}, 16'hFFFF, FIRST_DAY}, NO_RESULT},
        '{1'b0, '{KIND_SUB, '{5'd31, 4'd12, 14'd180}, 16'hFFFF, LAST_DAY}, NO_RESULT},
        '{1'b0, '{KIND_DIFF, '{5'd29, 4'd2, 14'd2000}, 16'd77,
                  '{5'd1, 4'd3, 14'd1900}}, NO_RESULT}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_kind;
    logic [4:0]               i_day;
    logic [3:0]               i_month;
    logic [YEAR_W-1:0]        i_year;
    logic [15:0]              i_day_count;
    logic [4:0]               i_other_day;
    logic [3:0]               i_other_month;
    logic [YEAR_W-1:0]        i_other_year;
    logic                     o_valid;
    logic [4:0]               o_result_day;
    logic [3:0]               o_result_month;
    logic [YEAR_W-1:0]        o_result_year;
    logic signed [DIFF_W-1:0] o_day_difference;
    logic                     o_out_of_range;

    pending_t awaited_dates[$];
    int       mismatches  = 0;
    int       stall_count = 0;

    gregorian_date_arithmetic_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_day            (i_day),
        .i_month          (i_month),
        .i_year           (i_year),
        .i_day_count      (i_day_count),
        .i_other_day      (i_other_day),
        .i_other_month    (i_other_month),
        .i_other_year     (i_other_year),
        .o_valid          (o_valid),
        .o_result_day     (o_result_day),
        .o_result_month   (o_result_month),
        .o_result_year    (o_result_year),
        .o_day_difference (o_day_difference),
        .o_out_of_range   (o_out_of_range)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- calendar predictor ----------------

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m == 2) return leap_year(y) ? 29 : 28;
        return 31;
    endfunction

    // Day serial with 1/1/1 as day 1; malformed fields are clamped first
    function automatic int serial_day(input cal_date_t dt);
        int y;
        int m;
        int d;
        int p;
        int total;
        y = dt.year;
        m = dt.month;
        d = dt.day;
        if (y < 1) y = 1;
        if (y > 9999) y = 9999;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        if (d < 1) d = 1;
        if (d > days_in_month(m, y)) d = days_in_month(m, y);
        p = y - 1;
        total = p * 365 + p / 4 - p / 100 + p / 400;
        for (int k = 1; k < m; k++) total += days_in_month(k, y);
        return total + d;
    endfunction

    // Inverse: estimate the year low, then walk forward
    function automatic cal_date_t date_of_serial(input int s);
        int y;
        int m;
        int r;
        cal_date_t dt;
        y = (s - 1) / 366 + 1;
        while (y < 9999 && serial_day('{5'd1, 4'd1, YEAR_W'(y + 1)}) <= s) y++;
        r = s - serial_day('{5'd1, 4'd1, YEAR_W'(y)});
        m = 1;
        while (m < 12 && r >= days_in_month(m, y)) begin
            r -= days_in_month(m, y);
            m++;
        end
        dt.day   = 5'(r + 1);
        dt.month = 4'(m);
        dt.year  = YEAR_W'(y);
        return dt;
    endfunction

    function automatic date_result_t predict_date_op(input date_item_t it);
        date_result_t res;
        int s;
        int span;
        res  = '0;
        span = int'(it.count & 16'((1 << COUNT_WIDTH) - 1));
        case (it.kind)
            KIND_ADD, KIND_SUB: begin
                s = serial_day(it.first);
                s = (it.kind == KIND_ADD) ? s + span : s - span;
                if (s > LAST_SERIAL) begin
                    s = LAST_SERIAL;
                    res.oor = 1'b1;
                end
                if (s < 1) begin
                    s = 1;
                    res.oor = 1'b1;
                end
                res.date = date_of_serial(s);
            end
            KIND_DIFF: res.diff = DIFF_W'(serial_day(it.first) - serial_day(it.second));
            default: res = '0;
        endcase
        return res;
    endfunction

    // ---------------- random items ----------------

    function automatic cal_date_t random_date();
        cal_date_t dt;
        int sel;
        int y;
        int m;
        sel = $urandom_range(99);
        if (sel < 12) begin
            // raw bits, mostly malformed
            dt.day   = 5'($urandom);
            dt.month = 4'($urandom);
            dt.year  = YEAR_W'($urandom);
        end else begin
            if (sel < 30) y = $urandom_range(1, 40);
            else if (sel < 48) y = $urandom_range(9960, 9999);
            else y = $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            dt.year  = YEAR_W'(y);
            dt.month = 4'(m);
            dt.day   = ($urandom_range(9) == 0) ? 5'(days_in_month(m, y))
                                                : 5'($urandom_range(1, days_in_month(m, y)));
        end
        return dt;
    endfunction

    function automatic date_item_t random_item();
        date_item_t it;
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) it.kind = KIND_ADD;
        else if (sel < 80) it.kind = KIND_SUB;
        else if (sel < 96) it.kind = KIND_DIFF;
        else it.kind = KIND_UNUSED;
        sel = $urandom_range(99);
        if (sel < 35) it.count = 16'($urandom);
        else if (sel < 60) it.count = 16'($urandom_range(0, 400));
        else if (sel < 80) it.count = 16'($urandom_range(60000, 65535));
        else it.count = 16'($urandom_range(0, 4000));
        it.first  = random_date();
        it.second = random_date();
        return it;
    endfunction

    // ---------------- driving ----------------

    task automatic send_item(input date_item_t it, input logic known, input date_result_t typed,
                             input int idle_pct);
        int gap;
        pending_t entry;
        gap = 0;
        while (gap < 400 && $urandom_range(99) < idle_pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        i_kind        <= it.kind;
        i_day         <= it.first.day;
        i_month       <= it.first.month;
        i_year        <= it.first.year;
        i_day_count   <= it.count;
        i_other_day   <= it.second.day;
        i_other_month <= it.second.month;
        i_other_year  <= it.second.year;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        entry.it  = it;
        entry.res = known ? typed : predict_date_op(it);
        awaited_dates.push_back(entry);
    endtask

    // Drop start and hold off until every result is back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items, input int idle_pct);
        for (int i = 0; i < n_items; i++) send_item(random_item(), 1'b0, NO_RESULT, idle_pct);
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        pending_t     want;
        date_result_t got;
        if (i_rst_n && o_valid) begin
            got = '{'{o_result_day, o_result_month, o_result_year}, o_day_difference,
                    o_out_of_range};
            if (awaited_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result %0d/%0d/%0d diff %0d oor %0d", got.date.day,
                             got.date.month, got.date.year, got.diff, got.oor);
            end else begin
                want = awaited_dates.pop_front();
                if (got !== want.res) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch kind %0d %0d/%0d/%0d n %0d %0d/%0d/%0d",
                                 want.it.kind, want.it.first.day, want.it.first.month,
                                 want.it.first.year, want.it.count, want.it.second.day,
                                 want.it.second.month, want.it.second.year);
                        $display("  expected %0d/%0d/%0d diff %0d oor %0d",
                                 want.res.date.day, want.res.date.month,
                                 want.res.date.year, want.res.diff, want.res.oor);
                        $display("  actual   %0d/%0d/%0d diff %0d oor %0d",
                                 got.date.day, got.date.month, got.date.year,
                                 got.diff, got.oor);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with neither an accepted item nor a result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = KIND_ADD;
        i_day         = 5'd1;
        i_month       = 4'd1;
        i_year        = 14'd1;
        i_day_count   = 16'd0;
        i_other_day   = 5'd1;
        i_other_month = 4'd1;
        i_other_year  = 14'd1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].it, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res, 0);
        drain();

        // back to back, sparse sender, light gaps, back to back again
        random_phase(70, 0);
        random_phase(70, 83);
        drain();
        random_phase(70, 16);
        random_phase(60, 0);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_dates.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
